/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

/* design/stunp_pkg.sv */
`default_nettype none

package stunp_pkg;

   localparam int HEADER_BYTES = 20;
   localparam int ID_BYTES     = 12;

   localparam int COUNT_W     = 17;
   localparam int TYPE_W      = 16;
   localparam int LENGTH_W    = 16;
   localparam int COOKIE_W    = 32;
   localparam int TXN_HI_W    = 32;
   localparam int TXN_LO_W    = 64;
   localparam int METHOD_W    = 12;
   localparam int CLASS_W     = 2;

   localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
   localparam logic [COOKIE_W-1:0] COOKIE_RESET = 32'h2112_A442;

   localparam logic [TYPE_W-1:0] MASK_TYPE_BITS = 16'hC000;
   localparam logic [TYPE_W-1:0] MASK_METHOD_HI = 16'h3E00;
   localparam logic [TYPE_W-1:0] MASK_METHOD_MID = 16'h00E0;
   localparam logic [TYPE_W-1:0] MASK_METHOD_LO = 16'h000F;
   localparam logic [TYPE_W-1:0] MASK_CLASS_HI  = 16'h0100;
   localparam logic [TYPE_W-1:0] MASK_CLASS_LO  = 16'h0010;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_SHORT     = 3'd1,
      STATUS_TYPE_BITS = 3'd2,
      STATUS_UNALIGNED = 3'd3,
      STATUS_OVERLONG  = 3'd4,
      STATUS_COOKIE    = 3'd5,
      STATUS_OVERRUN   = 3'd6
   } status_type;

   typedef enum logic {
      KIND_ATTR    = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_datagram;
   } req_type;

   typedef struct packed {
      kind_type              record_kind;
      logic [TYPE_W-1:0]     attr_type;
      logic [COUNT_W-1:0]    attr_offset;
      logic [LENGTH_W-1:0]   attr_length;
      logic [METHOD_W-1:0]   method;
      logic [CLASS_W-1:0]    msg_class;
      logic [TXN_HI_W-1:0]   txn_id_hi;
      logic [TXN_LO_W-1:0]   txn_id_lo;
      status_type            status;
      logic                  last;
   } rsp_type;

   // Up to two records leave the parser for one byte; they enter the queue in order.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } result_pair_type;

   function automatic logic [METHOD_W-1:0] unpack_method(input logic [TYPE_W-1:0] t);
      logic [TYPE_W-1:0] m;
      m = ((t & MASK_METHOD_HI) >> 2) | ((t & MASK_METHOD_MID) >> 1) | (t & MASK_METHOD_LO);
      return m[METHOD_W-1:0];
   endfunction

   function automatic logic [CLASS_W-1:0] unpack_class(input logic [TYPE_W-1:0] t);
      logic [TYPE_W-1:0] c;
      c = ((t & MASK_CLASS_HI) >> 7) | ((t & MASK_CLASS_LO) >> 4);
      return c[CLASS_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* design/stunp_parse.sv */
`default_nettype none
`include "assert_macros.svh"

module stunp_parse
   import stunp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire req_type             req_data,
   input  wire logic                csr_write_enable,
   input  wire logic [COOKIE_W-1:0] csr_write_data,
   output result_pair_type          results
);

   typedef enum logic [1:0] {
      PHASE_HEADER  = 2'd0,
      PHASE_VALUE   = 2'd1,
      PHASE_STOPPED = 2'd2
   } phase_type;

   logic [COOKIE_W-1:0] magic_ff;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [TYPE_W-1:0]   mtype_ff, mtype_in;
   logic [LENGTH_W-1:0] decl_ff, decl_in;
   logic [COOKIE_W-1:0] cookie_ff, cookie_in;
   logic [TXN_HI_W-1:0] txn_hi_ff, txn_hi_in;
   logic [TXN_LO_W-1:0] txn_lo_ff, txn_lo_in;
   phase_type           phase_ff, phase_in;
   logic [TYPE_W-1:0]   atype_ff, atype_in;
   logic [LENGTH_W-1:0] alen_ff, alen_in;
   logic [COUNT_W-1:0]  remain_ff, remain_in;
   logic                overrun_ff, overrun_in;

   logic [COUNT_W-1:0]  region_end;
   logic [LENGTH_W-1:0] len_full;
   logic [COUNT_W-1:0]  padded;
   logic [COUNT_W:0]    voff;
   logic                attr_hit;
   rsp_type             attr_rec;
   rsp_type             verdict;
   status_type          status;
   logic [7:0]          b;

   always_comb begin
      b          = req_data.data_byte;
      region_end = COUNT_W'(HEADER_BYTES) + {1'b0, decl_ff};
      count_in   = count_ff;
      mtype_in   = mtype_ff;
      decl_in    = decl_ff;
      cookie_in  = cookie_ff;
      txn_hi_in  = txn_hi_ff;
      txn_lo_in  = txn_lo_ff;
      phase_in   = phase_ff;
      atype_in   = atype_ff;
      alen_in    = alen_ff;
      remain_in  = remain_ff;
      overrun_in = overrun_ff;
      len_full   = {alen_ff[7:0], b};
      padded     = ({1'b0, len_full} + COUNT_W'(3)) & ~COUNT_W'(3);
      voff       = {1'b0, count_ff} + (COUNT_W+1)'(1);
      attr_hit   = 1'b0;
      attr_rec   = '0;
      verdict    = '0;
      status     = STATUS_OK;

      if (count_ff < COUNT_W'(HEADER_BYTES)) begin
         if (count_ff < COUNT_W'(2)) begin
            mtype_in = {mtype_ff[7:0], b};
         end else if (count_ff < COUNT_W'(4)) begin
            decl_in = {decl_ff[7:0], b};
         end else if (count_ff < COUNT_W'(8)) begin
            cookie_in = {cookie_ff[COOKIE_W-9:0], b};
         end else if (count_ff < COUNT_W'(HEADER_BYTES - ID_BYTES + 4)) begin
            txn_hi_in = {txn_hi_ff[TXN_HI_W-9:0], b};
         end else begin
            txn_lo_in = {txn_lo_ff[TXN_LO_W-9:0], b};
         end
      end else if (count_ff < region_end) begin
         case (phase_ff)
            PHASE_HEADER: begin
               case (count_ff[1:0])
                  2'd0: atype_in = {8'd0, b};
                  2'd1: atype_in = {atype_ff[7:0], b};
                  2'd2: alen_in = {8'd0, b};
                  default: begin
                     alen_in = len_full;
                     if ((voff + {1'b0, padded}) <= {1'b0, region_end}) begin
                        attr_hit             = 1'b1;
                        attr_rec.record_kind = KIND_ATTR;
                        attr_rec.attr_type   = atype_ff;
                        attr_rec.attr_offset = voff[COUNT_W-1:0];
                        attr_rec.attr_length = len_full;
                        if (padded != '0) begin
                           remain_in = padded;
                           phase_in  = PHASE_VALUE;
                        end
                     end else begin
                        overrun_in = 1'b1;
                        phase_in   = PHASE_STOPPED;
                     end
                  end
               endcase
            end
            PHASE_VALUE: begin
               if (remain_ff != '0) begin
                  remain_in = remain_ff - COUNT_W'(1);
               end
               if (remain_in == '0) begin
                  phase_in = PHASE_HEADER;
               end
            end
            default: ;
         endcase
      end

      if (count_ff != COUNT_MAX) begin
         count_in = count_ff + COUNT_W'(1);
      end

      if (count_in < COUNT_W'(HEADER_BYTES)) begin
         status = STATUS_SHORT;
      end else if ((mtype_in & MASK_TYPE_BITS) != '0) begin
         status = STATUS_TYPE_BITS;
      end else if (decl_in[1:0] != 2'd0) begin
         status = STATUS_UNALIGNED;
      end else if (region_end > count_in) begin
         status = STATUS_OVERLONG;
      end else if (cookie_in != magic_ff) begin
         status = STATUS_COOKIE;
      end else if (overrun_in) begin
         status = STATUS_OVERRUN;
      end

      verdict.record_kind = KIND_VERDICT;
      verdict.status      = status;
      verdict.last        = 1'b1;
      if (status == STATUS_OK) begin
         verdict.method    = unpack_method(mtype_in);
         verdict.msg_class = unpack_class(mtype_in);
         verdict.txn_id_hi = txn_hi_in;
         verdict.txn_id_lo = txn_lo_in;
      end

      results = '0;
      if (accept) begin
         if (attr_hit) begin
            attr_rec.last  = !req_data.end_of_datagram;
            results.first  = attr_rec;
            results.second = verdict;
            results.count  = req_data.end_of_datagram ? 2'd2 : 2'd1;
         end else if (req_data.end_of_datagram) begin
            results.first = verdict;
            results.count = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= COOKIE_RESET;
         count_ff   <= '0;
         mtype_ff   <= '0;
         decl_ff    <= '0;
         cookie_ff  <= '0;
         txn_hi_ff  <= '0;
         txn_lo_ff  <= '0;
         phase_ff   <= PHASE_HEADER;
         atype_ff   <= '0;
         alen_ff    <= '0;
         remain_ff  <= '0;
         overrun_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            magic_ff <= csr_write_data;
         end
         if (accept) begin
            if (req_data.end_of_datagram) begin
               count_ff   <= '0;
               mtype_ff   <= '0;
               decl_ff    <= '0;
               cookie_ff  <= '0;
               txn_hi_ff  <= '0;
               txn_lo_ff  <= '0;
               phase_ff   <= PHASE_HEADER;
               atype_ff   <= '0;
               alen_ff    <= '0;
               remain_ff  <= '0;
               overrun_ff <= 1'b0;
            end else begin
               count_ff   <= count_in;
               mtype_ff   <= mtype_in;
               decl_ff    <= decl_in;
               cookie_ff  <= cookie_in;
               txn_hi_ff  <= txn_hi_in;
               txn_lo_ff  <= txn_lo_in;
               phase_ff   <= phase_in;
               atype_ff   <= atype_in;
               alen_ff    <= alen_in;
               remain_ff  <= remain_in;
               overrun_ff <= overrun_in;
            end
         end
      end
   end

   `ASSERT_IMPLIES(a_stopped_means_overrun, clock, reset,
      phase_ff == PHASE_STOPPED, overrun_ff)
   `ASSERT_IMPLIES(a_value_has_bytes_left, clock, reset,
      phase_ff == PHASE_VALUE, remain_ff != '0)
   `ASSERT_IMPLIES(a_header_walk_idle, clock, reset,
      count_ff <= COUNT_W'(HEADER_BYTES), phase_ff == PHASE_HEADER && !overrun_ff)

endmodule

`default_nettype wire

/* design/stunp_queue.sv */
`default_nettype none
`include "assert_macros.svh"

module stunp_queue
   import stunp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire result_pair_type push,
   input  wire logic            rsp_stall,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   output logic                 full
);

   rsp_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [QUEUE_PTR_W-1:0] wr_next;
   logic                   pop;

   always_comb begin
      rsp_valid = count_ff != '0;
      rsp_data  = entry_ff[rd_ptr_ff];
      pop       = rsp_valid && !rsp_stall;
      full      = count_ff > QUEUE_CNT_W'(QUEUE_DEPTH - 2);
      wr_next   = wr_ptr_ff + QUEUE_PTR_W'(1);
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
      count_in  = count_ff + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_ALWAYS(a_count_in_range, clock, reset,
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
   `ASSERT_IMPLIES(a_no_push_when_full, clock, reset,
      full, push.count == 2'd0)
   `ASSERT_IMPLIES(a_pointers_agree, clock, reset,
      count_ff == '0, wr_ptr_ff == rd_ptr_ff)

endmodule

`default_nettype wire

/* design/stun_message_parser.sv */
// Channel   Direction  Beat          Handshake
// req_      in         one byte      req_valid / req_stall
// rsp_      out        one record    rsp_valid / rsp_stall
// csr_      in         magic cookie  csr_write_enable, no wait
//
// One byte is accepted per cycle while not stalled; its records are queued by the next cycle.
// A byte that completes an attribute header on the end of a datagram yields two beats.
// The four-entry output queue sets the rate: req_stall rises while fewer than two slots are free.
// Synchronous reset clears the parser state and the queue; the cookie returns to 0x2112A442.
// Stalling rsp_ only fills the queue; the parser state holds until bytes are accepted again.
`default_nettype none

module stun_message_parser
   import stunp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire req_type             req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_type                  rsp_data,
   input  wire logic                csr_write_enable,
   input  wire logic [COOKIE_W-1:0] csr_write_data
);

   result_pair_type results;
   logic            full;
   logic            accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   stunp_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .results          (results)
   );

   stunp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (results),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .full      (full)
   );

endmodule

`default_nettype wire
